@@ design/lcdp_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdp_pkg: shared types for the init command list player
// result codes, decoder phases and the beat structures of both channels
// ----------------------------------------------------------------------------
package lcdp_pkg;

    typedef enum logic [1:0] {
        KIND_CMD   = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_DELAY = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_CMD   = 5'b00010,
        PH_DESC  = 5'b00100,
        PH_ARGS  = 5'b01000,
        PH_DELAY = 5'b10000
    } phase_t;

    localparam logic [7:0] DELAY_LONG_CODE = 8'd255;
    localparam logic [8:0] DELAY_LONG_MS   = 9'd500;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       list_start;
    } table_beat_t;

    typedef struct packed {
        kind_t      kind;
        logic [8:0] value;
        logic       list_done;
    } result_t;

endpackage

@@ design/lcdp_in_if.sv @@
// ----------------------------------------------------------------------------
// lcdp_in_if: table byte channel
// valid/ready channel carrying one init table byte per beat
// ----------------------------------------------------------------------------
interface lcdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] table_byte;
    logic       list_start;

    modport source (output valid, output table_byte, output list_start, input ready);
    modport sink   (input valid, input table_byte, input list_start, output ready);
endinterface

@@ design/lcdp_out_if.sv @@
// ----------------------------------------------------------------------------
// lcdp_out_if: result channel
// valid/ready channel carrying one command, data or delay result per beat
// ----------------------------------------------------------------------------
interface lcdp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [8:0] value;
    logic       list_done;

    modport source (output valid, output kind, output value, output list_done, input ready);
    modport sink   (input valid, input kind, input value, input list_done, output ready);
endinterface

@@ design/lcdp_decoder.sv @@
// ----------------------------------------------------------------------------
// lcdp_decoder: input register and list decode
// holds one table byte, decodes it against the list state, offers a result
// ----------------------------------------------------------------------------
module lcdp_decoder
    import lcdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lcdp_in_if.sink       table_bytes,
    output logic          res_valid,
    output result_t       res,
    input  logic          res_ready
);

    logic        stage_valid_reg;
    table_beat_t stage_reg;
    logic        advance;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  cmds_reg,     cmds_next;
    logic [6:0]  args_reg,     args_next;
    logic        dly_reg,      dly_next;
    logic [7:0]  held_reg,     held_next;

    logic        emit;
    logic [6:0]  args_dec;
    logic [7:0]  cmds_dec;
    logic        last_cmd;
    logic [7:0]  b;

    assign b        = stage_reg.table_byte;
    assign args_dec = args_reg - 7'd1;
    assign cmds_dec = cmds_reg - 8'd1;
    assign last_cmd = (cmds_reg == 8'd1);

    // bytes without a result leave the stage regardless of the output side
    assign advance           = stage_valid_reg && (!emit || res_ready);
    assign table_bytes.ready = !stage_valid_reg || advance;
    assign res_valid         = stage_valid_reg && emit;

    always_comb
    begin
        phase_next = phase_reg;
        cmds_next  = cmds_reg;
        args_next  = args_reg;
        dly_next   = dly_reg;
        held_next  = held_reg;
        emit       = 1'b0;
        res        = '{kind: KIND_CMD, value: 9'd0, list_done: 1'b0};
        if (stage_reg.list_start)
        begin
            cmds_next  = b;
            args_next  = 7'd0;
            dly_next   = 1'b0;
            phase_next = (b != 8'd0) ? PH_CMD : PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_CMD:
                begin
                    held_next  = b;
                    phase_next = PH_DESC;
                end
                PH_DESC:
                begin
                    args_next = b[6:0];
                    dly_next  = b[7];
                    emit      = 1'b1;
                    res.kind  = KIND_CMD;
                    res.value = {1'b0, held_reg};
                    res.list_done = (b[6:0] == 7'd0) && !b[7] && last_cmd;
                    if (b[6:0] != 7'd0)
                        phase_next = PH_ARGS;
                    else if (b[7])
                        phase_next = PH_DELAY;
                    else
                    begin
                        cmds_next  = cmds_dec;
                        phase_next = (cmds_dec != 8'd0) ? PH_CMD : PH_IDLE;
                    end
                end
                PH_ARGS:
                begin
                    args_next = args_dec;
                    emit      = 1'b1;
                    res.kind  = KIND_DATA;
                    res.value = {1'b0, b};
                    res.list_done = (args_dec == 7'd0) && !dly_reg && last_cmd;
                    if (args_dec == 7'd0)
                    begin
                        if (dly_reg)
                            phase_next = PH_DELAY;
                        else
                        begin
                            cmds_next  = cmds_dec;
                            phase_next = (cmds_dec != 8'd0) ? PH_CMD : PH_IDLE;
                        end
                    end
                end
                PH_DELAY:
                begin
                    emit      = 1'b1;
                    res.kind  = KIND_DELAY;
                    res.value = (b == DELAY_LONG_CODE) ? DELAY_LONG_MS : {1'b0, b};
                    res.list_done = last_cmd;
                    dly_next   = 1'b0;
                    cmds_next  = cmds_dec;
                    phase_next = (cmds_dec != 8'd0) ? PH_CMD : PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            phase_reg       <= PH_IDLE;
            cmds_reg        <= 8'd0;
            args_reg        <= 7'd0;
            dly_reg         <= 1'b0;
            held_reg        <= 8'd0;
        end
        else
        begin
            if (table_bytes.ready)
                stage_valid_reg <= table_bytes.valid;
            if (advance)
            begin
                phase_reg <= phase_next;
                cmds_reg  <= cmds_next;
                args_reg  <= args_next;
                dly_reg   <= dly_next;
                held_reg  <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (table_bytes.ready && table_bytes.valid)
        begin
            stage_reg.table_byte <= table_bytes.table_byte;
            stage_reg.list_start <= table_bytes.list_start;
        end
    end

endmodule

@@ design/lcdp_out_buf.sv @@
// ----------------------------------------------------------------------------
// lcdp_out_buf: result register with skid entry
// full-rate output register, the skid entry absorbs one beat on a stall
// ----------------------------------------------------------------------------
module lcdp_out_buf
    import lcdp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    input  result_t       push_data,
    output logic          push_ready,
    lcdp_out_if.source    results
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;
    logic    push_fire;

    assign push_ready = !skid_valid_reg;
    assign push_fire  = push_valid && push_ready;

    assign results.valid     = main_valid_reg;
    assign results.kind      = main_reg.kind;
    assign results.value     = main_reg.value;
    assign results.list_done = main_reg.list_done;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (results.ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push_fire;
            end
        end
        else if (push_fire)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ design/lcd_init_command_list_player_core.sv @@
// ----------------------------------------------------------------------------
// lcd_init_command_list_player_core: display init table player
// turns init table bytes into command writes, data writes and delay requests
// ----------------------------------------------------------------------------
// usage
//   table_bytes : one table byte per beat; list_start marks the command count
//                 that opens a list, and restarts the player from any phase
//   results     : one beat per command byte, argument byte or delay byte;
//                 kind 0 command (dc low), 1 data (dc high), 2 delay in ms,
//                 delay code 255 reads as 500 ms; list_done on the last beat
//   the count byte, each command byte and any byte outside a list give no
//   beat; the command beat appears with its descriptor byte, so that it can
//   already carry list_done
//   an accepted byte is held in the input register, and its result passes
//   through the result register (or the skid entry on a stall) to the port
//   throughput: one byte per cycle while results are taken, set by the single
//   decode stage whose phase and counter registers update once per byte
//   reset: empties both registers and returns the player to idle
//   stall: the skid entry holds one more result, then table_bytes.ready drops
//   while a byte with a result waits, until the receiver takes a beat
// ----------------------------------------------------------------------------
module lcd_init_command_list_player_core
    import lcdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lcdp_in_if.sink     table_bytes,
    lcdp_out_if.source  results
);

    // decoded result offered to the output register
    logic    res_valid;
    logic    res_ready;
    result_t res;

    lcdp_decoder u_decoder
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_bytes (table_bytes),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    // output register plus skid entry, decouples a stalled receiver
    lcdp_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_data  (res),
        .push_ready (res_ready),
        .results    (results)
    );

endmodule

@@ tb/lcdp_result_checker.sv @@
// ----------------------------------------------------------------------------
// lcdp_result_checker: result scoreboard for the init command list player
// follows every accepted table byte, works out the beat it should produce and
// compares each result beat field by field with the oldest outstanding one
// ----------------------------------------------------------------------------
module lcdp_result_checker
    import lcdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    lcdp_in_if          in_ch,
    lcdp_out_if         out_ch,
    output int unsigned fail_count,
    output int unsigned waiting_count,
    output int unsigned result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // own copy of the player state
    phase_t      ph;
    logic [7:0]  cmds_left;
    logic [6:0]  args_left;
    logic        dly_pending;
    logic [7:0]  held_cmd;

    result_t     pending_results[$];
    int unsigned n_fail;
    int unsigned n_waiting;
    int unsigned n_results;

    assign fail_count    = n_fail;
    assign waiting_count = n_waiting;
    assign result_count  = n_results;

    task automatic queue_result(input kind_t k, input logic [8:0] v, input logic done);
        result_t r;
        r.kind      = k;
        r.value     = v;
        r.list_done = done;
        pending_results.push_back(r);
    endtask

    task automatic close_command();
        cmds_left = cmds_left - 8'd1;
        ph = (cmds_left != 8'd0) ? PH_CMD : PH_IDLE;
    endtask

    task automatic predict_table_byte(input logic [7:0] b, input logic s);
        logic last;
        if (s)
        begin
            cmds_left   = b;
            args_left   = 7'd0;
            dly_pending = 1'b0;
            ph = (b != 8'd0) ? PH_CMD : PH_IDLE;
        end
        else
        begin
            case (ph)
                PH_CMD:
                begin
                    held_cmd = b;
                    ph = PH_DESC;
                end
                PH_DESC:
                begin
                    args_left   = b[6:0];
                    dly_pending = b[7];
                    last = (args_left == 7'd0) && !dly_pending && (cmds_left == 8'd1);
                    queue_result(KIND_CMD, {1'b0, held_cmd}, last);
                    if (args_left != 7'd0)
                        ph = PH_ARGS;
                    else if (dly_pending)
                        ph = PH_DELAY;
                    else
                        close_command();
                end
                PH_ARGS:
                begin
                    args_left = args_left - 7'd1;
                    last = (args_left == 7'd0) && !dly_pending && (cmds_left == 8'd1);
                    queue_result(KIND_DATA, {1'b0, b}, last);
                    if (args_left == 7'd0)
                    begin
                        if (dly_pending)
                            ph = PH_DELAY;
                        else
                            close_command();
                    end
                end
                PH_DELAY:
                begin
                    queue_result(KIND_DELAY, (b == DELAY_LONG_CODE) ? DELAY_LONG_MS : {1'b0, b},
                                 cmds_left == 8'd1);
                    dly_pending = 1'b0;
                    close_command();
                end
                default:
                    ph = PH_IDLE;
            endcase
        end
    endtask

    task automatic check_result(input logic [1:0] k, input logic [8:0] v, input logic done);
        result_t want;
        n_results++;
        if (pending_results.size() == 0)
        begin
            n_fail++;
            $display("%0t ns: result beat with nothing expected, actual kind %0d value %0d done %0b",
                     $time, k, v, done);
        end
        else
        begin
            want = pending_results.pop_front();
            if (k !== want.kind)
            begin
                n_fail++;
                $display("%0t ns: kind mismatch, expected %0d actual %0d", $time, want.kind, k);
            end
            if (v !== want.value)
            begin
                n_fail++;
                $display("%0t ns: value mismatch, expected %0d actual %0d", $time, want.value, v);
            end
            if (done !== want.list_done)
            begin
                n_fail++;
                $display("%0t ns: list_done mismatch, expected %0b actual %0b",
                         $time, want.list_done, done);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph          = PH_IDLE;
            cmds_left   = 8'd0;
            args_left   = 7'd0;
            dly_pending = 1'b0;
            held_cmd    = 8'd0;
            pending_results.delete();
            n_fail      = 0;
            n_waiting   = 0;
            n_results   = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.kind, out_ch.value, out_ch.list_done);
            if (in_ch.valid && in_ch.ready)
                predict_table_byte(in_ch.table_byte, in_ch.list_start);
            n_waiting = pending_results.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for lcd_init_command_list_player_core
// plays directed and random init tables into the player with random gaps on
// both channels, one long receiver stall, and lets the checker score results
// ----------------------------------------------------------------------------
module tb_top
    import lcdp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TARGET_ITEMS     = 1350;
    localparam int unsigned PRESSURE_AT      = 500;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT       = 4000;
    localparam int unsigned TAIL_CYCLES      = 24;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lcdp_in_if  table_ch ();
    lcdp_out_if result_ch ();

    int unsigned fail_count;
    int unsigned waiting_count;
    int unsigned result_count;

    // idling controls for the two channel processes
    bit src_burst;
    bit snk_burst;
    bit long_hold_req;
    bit pressure_done;

    int unsigned beats_sent;
    int unsigned junk_beats;
    int unsigned lists_played;
    int unsigned lists_cut;
    int unsigned idle_cycles;

    initial
    begin
        forever #2 clk = ~clk;
    end

    lcd_init_command_list_player_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .table_bytes (table_ch),
        .results     (result_ch)
    );

    lcdp_result_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (table_ch),
        .out_ch        (result_ch),
        .fail_count    (fail_count),
        .waiting_count (waiting_count),
        .result_count  (result_count)
    );

    // one table byte: optional gap with valid low, then hold valid until taken
    // ready is looked at on the falling edge, where nothing is changing
    task automatic send_beat(input logic [7:0] b, input logic s);
        int unsigned gap;
        logic took;
        gap = src_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            table_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        table_ch.valid      <= 1'b1;
        table_ch.table_byte <= b;
        table_ch.list_start <= s;
        do
        begin
            @(negedge clk);
            took = table_ch.ready;
            @(posedge clk);
        end
        while (!took);
        beats_sent++;
    endtask

    // a full command: command byte, descriptor, arguments, optional delay byte
    task automatic play_command(input logic [7:0] cmd, input logic [6:0] nargs,
                                input logic dly);
        int unsigned r;
        send_beat(cmd, 1'b0);
        send_beat({dly, nargs}, 1'b0);
        repeat (nargs) send_beat(8'($urandom), 1'b0);
        if (dly)
        begin
            // the long delay code and a zero delay both get a fair share
            r = $urandom_range(0, 9);
            if (r < 2)
                send_beat(DELAY_LONG_CODE, 1'b0);
            else if (r < 3)
                send_beat(8'd0, 1'b0);
            else
                send_beat(8'($urandom), 1'b0);
        end
    endtask

    // a list with random content; some are cut short so that the next list start
    // lands before the list is over, others are followed by stray bytes
    task automatic play_random_list();
        int unsigned r;
        int unsigned n_play;
        int unsigned k;
        int unsigned part_args;
        logic [7:0]  count;
        logic [6:0]  nargs;
        bit          cut;
        r = $urandom_range(0, 99);
        if (r < 5)
            count = 8'd0;
        else if (r < 11)
            count = 8'($urandom_range(128, 255));
        else
            count = 8'($urandom_range(1, 6));
        n_play = 32'(count);
        cut    = 1'b0;
        if (count > 8'd8)
        begin
            // big counts only ever get a few commands before a restart
            n_play = $urandom_range(0, 3);
            cut    = 1'b1;
        end
        else if (count != 8'd0 && $urandom_range(0, 9) == 0)
        begin
            n_play = $urandom_range(0, count - 1);
            cut    = 1'b1;
        end
        src_burst = ($urandom_range(0, 4) == 0);
        send_beat(count, 1'b1);
        lists_played++;
        for (k = 0; k < n_play; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                nargs = 7'($urandom_range(0, 4));
            else if (r < 98)
                nargs = 7'($urandom_range(5, 16));
            else
                nargs = 7'($urandom_range(100, 127));
            play_command(8'($urandom), nargs, 1'($urandom));
        end
        if (cut)
        begin
            lists_cut++;
            // leave the player waiting for a command, descriptor, argument or delay
            case ($urandom_range(0, 3))
                0: ;
                1: send_beat(8'($urandom), 1'b0);
                2:
                begin
                    nargs     = 7'($urandom_range(2, 6));
                    part_args = $urandom_range(0, nargs - 1);
                    send_beat(8'($urandom), 1'b0);
                    send_beat({1'b0, nargs}, 1'b0);
                    repeat (part_args) send_beat(8'($urandom), 1'b0);
                end
                default:
                begin
                    send_beat(8'($urandom), 1'b0);
                    send_beat(8'h80, 1'b0);
                end
            endcase
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            // stray bytes once the list is over, all of them ignored
            r = $urandom_range(1, 3);
            repeat (r)
            begin
                send_beat(8'($urandom), 1'b0);
                junk_beats++;
            end
        end
    endtask

    // stimulus: reset, directed tables, random tables, then drain and verdict
    initial
    begin
        table_ch.valid      <= 1'b0;
        table_ch.table_byte <= 8'd0;
        table_ch.list_start <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte straight after reset, then an empty list
        send_beat(8'hA5, 1'b0);
        junk_beats++;
        send_beat(8'h00, 1'b1);
        lists_played++;

        // two commands: extreme command bytes, no arguments, then two
        // arguments with the long delay code
        send_beat(8'h02, 1'b1);
        lists_played++;
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h82, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(DELAY_LONG_CODE, 1'b0);

        // one command with a delay only, and a zero delay
        send_beat(8'h01, 1'b1);
        lists_played++;
        send_beat(8'h36, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h00, 1'b0);

        // restart while the arguments of a command are still coming
        send_beat(8'h03, 1'b1);
        lists_played++;
        lists_cut++;
        send_beat(8'h11, 1'b0);
        send_beat(8'h03, 1'b0);
        send_beat(8'h12, 1'b0);
        send_beat(8'h01, 1'b1);
        lists_played++;
        send_beat(8'h29, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'h7F, 1'b0);

        // bytes after the list has ended
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        junk_beats += 2;

        while ((beats_sent - junk_beats) < TARGET_ITEMS)
        begin
            if (!pressure_done && beats_sent >= PRESSURE_AT)
            begin
                // receiver stops for a long stretch while bytes keep coming
                // back to back, so the player fills up and drops ready
                pressure_done = 1'b1;
                src_burst     = 1'b1;
                long_hold_req = 1'b1;
                send_beat(8'h01, 1'b1);
                lists_played++;
                play_command(8'($urandom), 7'd40, 1'b1);
            end
            else
                play_random_list();
        end

        table_ch.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (waiting_count != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d table bytes (%0d stray) in %0d lists, %0d cut short by a restart",
                 beats_sent, junk_beats, lists_played, lists_cut);
        $display("checked %0d result beats, with a receiver stall of %0d cycles",
                 result_count, LONG_HOLD_CYCLES);
        if (fail_count == 0)
            $display("lcd_init_command_list_player_core test passed");
        else
            $display("lcd_init_command_list_player_core test failed");
        $finish;
    end

    // receiver: a random wait before each beat, bursts with no wait at all,
    // and once a long hold-off counted here
    initial
    begin
        int unsigned hold;
        logic took;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                snk_burst = !snk_burst;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD_CYCLES;
            end
            else
                hold = snk_burst ? 0 : $urandom_range(0, 19);
            if (hold != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = result_ch.valid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    // watchdog: too long without a beat on either channel ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((table_ch.valid && table_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t ns: no beat on either channel for %0d cycles", $time, IDLE_LIMIT);
                $display("lcd_init_command_list_player_core test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
